// ===== design/dmavm_pkg.sv =====
`default_nettype none
package dmavm_pkg;

	localparam int VOICE_COUNT        = 4;
	localparam int RAM_ADDR_BITS_DEF  = 16;
	localparam int PHASE_BITS_DEF     = 24;
	localparam int RATE_W             = 23;
	localparam logic [RATE_W-1:0] RATE_RESET = 23'd4842691;

	localparam logic [23:0] DMA_CTRL_ADDR = 24'hDFF096;
	localparam logic [23:0] VOICE_BASE    = 24'hDFF0A0;
	localparam logic [23:0] VOICE_SPAN    = 24'h000040;
	localparam logic [3:0]  OFF_PTR       = 4'h0;
	localparam logic [3:0]  OFF_LEN       = 4'h4;
	localparam logic [3:0]  OFF_PER       = 4'h6;
	localparam logic [3:0]  OFF_VOL       = 4'h8;
	localparam logic [15:0] START_BIT     = 16'h8000;
	localparam logic [15:0] PERIOD_MIN    = 16'd113;
	localparam logic [16:0] PERIOD_ZERO   = 17'd65536;
	localparam logic [6:0]  VOL_MAX       = 7'd64;

	typedef enum logic [1:0] {
		KIND_WORD = 2'd0,
		KIND_PTR  = 2'd1,
		KIND_TICK = 2'd2,
		KIND_LOAD = 2'd3
	} kind_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_VOICE = 7'b0000100,
		ST_RD1   = 7'b0001000,
		ST_RD2   = 7'b0010000,
		ST_FIN   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

endpackage
`default_nettype wire

// ===== design/dmavm_if.sv =====
`default_nettype none
interface dmavm_item_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [23:0]       bus_address;
	logic [15:0]       write_data;
	logic [15:0]       mem_address;
	logic signed [7:0] mem_data;
	modport source (output valid, kind, bus_address, write_data, mem_address, mem_data,
		input ready);
	modport sink (input valid, kind, bus_address, write_data, mem_address, mem_data,
		output ready);
endinterface

interface dmavm_result_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] left_out;
	logic signed [14:0] right_out;
	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

interface dmavm_cfg_if;
	logic        valid;
	logic        ready;
	logic [22:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/dma_audio_voice_mixer.sv =====
// A tick visits the voices in turn, and a voice that refills its byte buffer reads it
// through the single read port of the sample RAM; the sums then go to the result
// register, which also waits for the previous result to be taken. A period write runs
// a bit-serial divider, and no further item is accepted until it is done.
// Reset: arst_n clears all voice state and loads the default rate ratio; the sample RAM
// is not cleared and must be loaded before playback.
`default_nettype none
module dma_audio_voice_mixer import dmavm_pkg::*; #(
	parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEF,
	parameter int PHASE_BITS    = PHASE_BITS_DEF
) (
	input wire logic       clk,
	input wire logic       arst_n,
	dmavm_item_if.sink     items,
	dmavm_result_if.source results,
	dmavm_cfg_if.sink      cfg
);
	localparam int AW    = RAM_ADDR_BITS;
	localparam int FRAC  = PHASE_BITS - 1;
	localparam int NW    = RATE_W + FRAC;
	localparam int DW    = 33;
	localparam int CW    = $clog2(NW + 1);
	localparam logic [PHASE_BITS-1:0] STEP_MAX = {1'b0, {FRAC{1'b1}}};

	state_t state_q;
	logic [RATE_W-1:0] rate_q;
	logic [1:0] v_q;

	logic                     active_q [VOICE_COUNT];
	logic                     started_q [VOICE_COUNT];
	logic                     pending_q [VOICE_COUNT];
	logic [7:0]               first_q [VOICE_COUNT];
	logic [7:0]               second_q [VOICE_COUNT];
	logic [AW-1:0]            pa_q [VOICE_COUNT];
	logic [15:0]              wl_q [VOICE_COUNT];
	logic                     bl_q [VOICE_COUNT];
	logic signed [13:0]       held_q [VOICE_COUNT];
	logic [PHASE_BITS-1:0]    stepn_q [VOICE_COUNT];
	logic [PHASE_BITS-1:0]    phase_q [VOICE_COUNT];
	logic [15:0]              sa_q [VOICE_COUNT];
	logic [15:0]              sl_q [VOICE_COUNT];
	logic [6:0]               vol_q [VOICE_COUNT];
	logic [PHASE_BITS-1:0]    steps_q [VOICE_COUNT];

	logic [NW-1:0] num_q, quo_q;
	logic [DW-1:0] rem_q, den_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    dv_q;
	logic [7:0]    rbyte_q;

	logic signed [14:0] lacc_q, racc_q, lout_q, rout_q;
	logic res_valid_q;

	// Sample RAM.
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	dmavm_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(items.mem_address)),
		.wdata (items.mem_data),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic accept;
	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign ram_we      = accept && (items.kind == KIND_LOAD);
	assign cfg.ready   = 1'b1;

	assign results.valid     = res_valid_q;
	assign results.left_out  = lout_q;
	assign results.right_out = rout_q;

	// Register decode.
	logic [23:0] off24;
	logic        in_voice;
	logic [1:0]  wn;
	logic [3:0]  woff;
	assign off24    = items.bus_address - VOICE_BASE;
	assign in_voice = (items.bus_address >= VOICE_BASE) && (off24 < VOICE_SPAN);
	assign wn       = off24[5:4];
	assign woff     = off24[3:0];

	logic [16:0] per_eff;
	always_comb begin
		if (items.write_data == 16'd0) begin
			per_eff = PERIOD_ZERO;
		end else if (items.write_data < PERIOD_MIN) begin
			per_eff = {1'b0, PERIOD_MIN};
		end else begin
			per_eff = {1'b0, items.write_data};
		end
	end

	// Divider step.
	logic [DW:0]   trial;
	logic          qbit;
	logic [NW-1:0] quo_next;
	assign trial    = {rem_q, num_q[NW-1]};
	assign qbit     = (trial >= {1'b0, den_q});
	assign quo_next = {quo_q[NW-2:0], qbit};

	// Refill address for the current voice.
	logic [15:0]   wl_dec;
	logic [15:0]   wl_new;
	logic [AW-1:0] pa_use;
	always_comb begin
		wl_dec = wl_q[v_q] - 16'd1;
		wl_new = wl_q[v_q];
		pa_use = pa_q[v_q];
		if (!started_q[v_q]) begin
			wl_new = wl_dec;
			if (wl_dec == 16'd0) begin
				wl_new = sl_q[v_q];
				pa_use = AW'(sa_q[v_q]);
			end
		end
	end

	always_comb begin
		case (state_q)
			ST_RD1:  ram_raddr = pa_q[v_q] + AW'(1);
			default: ram_raddr = pa_use;
		endcase
	end

	// Scaled sample of the byte about to play.
	logic [7:0]         play_byte;
	logic signed [15:0] prod;
	assign play_byte = (state_q == ST_RD2) ? rbyte_q : first_q[v_q];
	assign prod      = $signed(play_byte) * $signed({9'd0, vol_q[v_q]});

	logic [PHASE_BITS-1:0] phase_sum;
	assign phase_sum = phase_q[v_q] + stepn_q[v_q];

	logic signed [14:0] held_ext;
	assign held_ext = 15'(held_q[v_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rate_q      <= RATE_RESET;
			v_q         <= '0;
			res_valid_q <= 1'b0;
			num_q <= '0; quo_q <= '0; rem_q <= '0; den_q <= '0; cnt_q <= '0; dv_q <= '0;
			rbyte_q <= '0;
			lacc_q <= '0; racc_q <= '0; lout_q <= '0; rout_q <= '0;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				active_q[i] <= 1'b0; started_q[i] <= 1'b0; pending_q[i] <= 1'b0;
				first_q[i] <= '0; second_q[i] <= '0; pa_q[i] <= '0; wl_q[i] <= '0;
				bl_q[i] <= 1'b0; held_q[i] <= '0; stepn_q[i] <= '0; phase_q[i] <= '0;
				sa_q[i] <= '0; sl_q[i] <= '0; vol_q[i] <= '0; steps_q[i] <= '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				rate_q <= cfg.data;
			end
			if (res_valid_q && results.ready && state_q != ST_OUT) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (items.kind)
							KIND_WORD: begin
								if (items.bus_address == DMA_CTRL_ADDR) begin
									for (int i = 0; i < VOICE_COUNT; i++) begin
										if (items.write_data[i]) begin
											if ((items.write_data & START_BIT) != 16'd0) begin
												pa_q[i]      <= AW'(sa_q[i]);
												wl_q[i]      <= sl_q[i];
												bl_q[i]      <= 1'b0;
												started_q[i] <= 1'b1;
												stepn_q[i]   <= steps_q[i];
												pending_q[i] <= 1'b1;
												phase_q[i]   <= '0;
												active_q[i]  <= 1'b1;
											end else begin
												active_q[i] <= 1'b0;
											end
										end
									end
								end else if (in_voice) begin
									case (woff)
										OFF_LEN: sl_q[wn] <= items.write_data;
										OFF_PER: begin
											num_q   <= NW'(rate_q) << FRAC;
											den_q   <= {per_eff, 16'd0};
											rem_q   <= '0;
											quo_q   <= '0;
											cnt_q   <= '0;
											dv_q    <= wn;
											state_q <= ST_DIV;
										end
										OFF_VOL: begin
											vol_q[wn] <= (items.write_data[6:0] > VOL_MAX) ?
												VOL_MAX : items.write_data[6:0];
										end
										default: ;
									endcase
								end
							end
							KIND_PTR: begin
								if (in_voice && woff == OFF_PTR) begin
									sa_q[wn] <= items.write_data;
								end
							end
							KIND_TICK: begin
								v_q     <= '0;
								lacc_q  <= '0;
								racc_q  <= '0;
								state_q <= ST_VOICE;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					rem_q <= qbit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
					num_q <= {num_q[NW-2:0], 1'b0};
					quo_q <= quo_next;
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(NW - 1)) begin
						if (quo_next[NW-1:FRAC] != '0) begin
							steps_q[dv_q] <= STEP_MAX;
						end else begin
							steps_q[dv_q] <= PHASE_BITS'(quo_next[FRAC-1:0]);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_VOICE: begin
					state_q <= ST_FIN;
					if (active_q[v_q] && pending_q[v_q]) begin
						pending_q[v_q] <= 1'b0;
						if (!bl_q[v_q]) begin
							// The buffer is empty: refill it from two RAM reads.
							wl_q[v_q]      <= wl_new;
							pa_q[v_q]      <= pa_use;
							started_q[v_q] <= 1'b0;
							state_q        <= ST_RD1;
						end else begin
							held_q[v_q]  <= prod[13:0];
							first_q[v_q] <= second_q[v_q];
							bl_q[v_q]    <= 1'b0;
						end
					end
				end
				ST_RD1: begin
					rbyte_q <= ram_rdata;
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					held_q[v_q]   <= prod[13:0];
					first_q[v_q]  <= ram_rdata;
					second_q[v_q] <= ram_rdata;
					bl_q[v_q]     <= 1'b1;
					pa_q[v_q]     <= pa_q[v_q] + AW'(2);
					state_q       <= ST_FIN;
				end
				ST_FIN: begin
					if (active_q[v_q]) begin
						if (v_q == 2'd0 || v_q == 2'd3) begin
							lacc_q <= lacc_q + held_ext;
						end else begin
							racc_q <= racc_q + held_ext;
						end
						if (phase_sum[PHASE_BITS-1]) begin
							phase_q[v_q]   <= {1'b0, phase_sum[FRAC-1:0]};
							stepn_q[v_q]   <= steps_q[v_q];
							pending_q[v_q] <= 1'b1;
						end else begin
							phase_q[v_q] <= phase_sum;
						end
					end
					v_q     <= v_q + 2'd1;
					state_q <= (v_q == 2'd3) ? ST_OUT : ST_VOICE;
				end
				ST_OUT: begin
					// The previous result must have been transferred first.
					if (!res_valid_q || results.ready) begin
						lout_q      <= lacc_q;
						rout_q      <= racc_q;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/dmavm_ram.sv =====
`default_nettype none
module dmavm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== tb/dmavm_tb_pkg.sv =====
`timescale 1ns / 1ps
package dmavm_tb_pkg;
	import dmavm_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [23:0] bus_address;
		logic [15:0] write_data;
		logic [15:0] mem_address;
		logic [7:0]  mem_data;
		logic        check_fixed;
		logic [14:0] fixed_left;
		logic [14:0] fixed_right;
	} stim_row_t;

	typedef struct {
		logic [14:0] left;
		logic [14:0] right;
	} mix_pair_t;
endpackage

// ===== tb/dma_audio_voice_mixer_tb.sv =====
`timescale 1ns / 1ps
module dma_audio_voice_mixer_tb;
	import dmavm_pkg::*;
	import dmavm_tb_pkg::*;

	localparam longint PHASE_ONE = 64'd1 << 23;
	localparam longint CYCLE_LIMIT = 1500000;

	logic clk;
	logic arst_n;
	dmavm_item_if   items();
	dmavm_result_if results();
	dmavm_cfg_if    cfg();

	dma_audio_voice_mixer u_top (
		.clk(clk), .arst_n(arst_n), .items(items), .results(results), .cfg(cfg)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Shadow copy of the mixer state.
	logic [7:0]  ram_shadow [0:65535];
	logic        ram_known [0:65535];
	logic [3:0]  v_active, v_fresh, v_fetch;
	logic [7:0]  v_first [4], v_second [4];
	logic [15:0] v_addr [4], v_words [4], v_start [4], v_len [4];
	logic [1:0]  v_bytes [4];
	int          v_held [4];
	longint      v_step [4], v_phase [4], v_step_next [4];
	int          v_vol [4];
	longint      rate_now;

	mix_pair_t   pending_mix[$];
	int          fails;
	longint      cycles;
	logic        idle_free;

	task automatic clear_shadow();
		for (int n = 0; n < 4; n++) begin
			v_first[n] = 0; v_second[n] = 0; v_addr[n] = 0; v_words[n] = 0;
			v_start[n] = 0; v_len[n] = 0; v_bytes[n] = 0; v_held[n] = 0;
			v_step[n] = 0; v_phase[n] = 0; v_step_next[n] = 0; v_vol[n] = 0;
		end
		v_active = 0; v_fresh = 0; v_fetch = 0;
		rate_now = RATE_RESET;
		for (int a = 0; a < 65536; a++) begin
			ram_known[a] = 1'b0;
			ram_shadow[a] = 8'h00;
		end
	endtask

	function automatic longint period_step(logic [15:0] per);
		longint p, s;
		p = (per == 0) ? 65536 : ((per < PERIOD_MIN) ? 113 : per);
		s = (rate_now << 23) / (p << 16);
		return (s > PHASE_ONE - 1) ? PHASE_ONE - 1 : s;
	endfunction

	function automatic void refill_voice(int n);
		if (v_bytes[n] == 0) begin
			if (!v_fresh[n]) begin
				v_words[n] = v_words[n] - 16'd1;
				if (v_words[n] == 0) begin
					v_words[n] = v_len[n];
					v_addr[n] = v_start[n];
				end
			end
			v_fresh[n] = 1'b0;
			v_first[n] = ram_shadow[v_addr[n]];
			v_second[n] = ram_shadow[16'(v_addr[n] + 16'd1)];
			v_addr[n] = v_addr[n] + 16'd2;
			v_bytes[n] = 2;
		end
		v_held[n] = int'($signed(v_first[n])) * v_vol[n];
		v_first[n] = v_second[n];
		v_bytes[n] = v_bytes[n] - 2'd1;
	endfunction

	// Applies one item to the shadow state; returns 1 and the mix for a tick.
	function automatic bit mix_item(stim_row_t r, output mix_pair_t mix);
		int left, right, n;
		logic [23:0] off;
		left = 0; right = 0;
		mix.left = 0; mix.right = 0;
		case (r.kind)
			KIND_WORD: begin
				if (r.bus_address == DMA_CTRL_ADDR) begin
					for (n = 0; n < 4; n++) if (r.write_data[n]) begin
						if (r.write_data[15]) begin
							v_addr[n] = v_start[n]; v_words[n] = v_len[n];
							v_bytes[n] = 0; v_fresh[n] = 1'b1;
							v_step[n] = v_step_next[n]; v_fetch[n] = 1'b1;
							v_phase[n] = 0; v_active[n] = 1'b1;
						end else
							v_active[n] = 1'b0;
					end
				end else if (r.bus_address >= VOICE_BASE &&
						r.bus_address < VOICE_BASE + VOICE_SPAN) begin
					off = r.bus_address - VOICE_BASE;
					n = off[5:4];
					if (off[3:0] == OFF_LEN) v_len[n] = r.write_data;
					else if (off[3:0] == OFF_PER) v_step_next[n] = period_step(r.write_data);
					else if (off[3:0] == OFF_VOL)
						v_vol[n] = (r.write_data[6:0] > VOL_MAX) ? 64 : r.write_data[6:0];
				end
				return 0;
			end
			KIND_PTR: begin
				off = r.bus_address - VOICE_BASE;
				if (r.bus_address >= VOICE_BASE && r.bus_address < VOICE_BASE + VOICE_SPAN &&
						off[3:0] == OFF_PTR)
					v_start[off[5:4]] = r.write_data;
				return 0;
			end
			KIND_LOAD: begin
				ram_shadow[r.mem_address] = r.mem_data;
				ram_known[r.mem_address] = 1'b1;
				return 0;
			end
			default: begin
				for (n = 0; n < 4; n++) begin
					if (!v_active[n]) continue;
					if (v_fetch[n]) begin
						v_fetch[n] = 1'b0;
						refill_voice(n);
					end
					if (n == 0 || n == 3) left += v_held[n];
					else right += v_held[n];
					v_phase[n] += v_step[n];
					if (v_phase[n] >= PHASE_ONE) begin
						v_phase[n] -= PHASE_ONE;
						v_step[n] = v_step_next[n];
						v_fetch[n] = 1'b1;
					end
				end
				mix.left = left[14:0];
				mix.right = right[14:0];
				return 1;
			end
		endcase
	endfunction

	task automatic send_item(stim_row_t r);
		mix_pair_t mix;
		if (!idle_free) while ($urandom_range(99) < 15) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid <= 1'b1;
		items.kind <= r.kind;
		items.bus_address <= r.bus_address;
		items.write_data <= r.write_data;
		items.mem_address <= r.mem_address;
		items.mem_data <= r.mem_data;
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		if (mix_item(r, mix)) begin
			if (r.check_fixed) begin
				mix.left = r.fixed_left;
				mix.right = r.fixed_right;
			end
			pending_mix.push_back(mix);
		end
	endtask

	task automatic write_rate(logic [22:0] value);
		items.valid <= 1'b0;
		while (pending_mix.size() != 0) @(posedge clk);
		// Period writes occupy a divider for a while after their transfer.
		repeat (100) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		rate_now = value;
	endtask

	function automatic stim_row_t row(kind_t k, logic [23:0] a, logic [15:0] d,
			logic [15:0] ma = 0, logic [7:0] md = 0);
		stim_row_t r;
		r.kind = k; r.bus_address = a; r.write_data = d;
		r.mem_address = ma; r.mem_data = md;
		r.check_fixed = 0; r.fixed_left = 0; r.fixed_right = 0;
		return r;
	endfunction

	function automatic stim_row_t fixed_tick(logic [14:0] l, logic [14:0] rr);
		stim_row_t r;
		r = row(KIND_TICK, 0, 0);
		r.check_fixed = 1; r.fixed_left = l; r.fixed_right = rr;
		return r;
	endfunction

	// Random register write, biased to real voice registers.
	function automatic stim_row_t random_write();
		logic [23:0] a;
		logic [15:0] d;
		int n;
		n = $urandom_range(3);
		d = $urandom;
		case ($urandom_range(9))
			0: a = $urandom;
			1: a = VOICE_BASE + 16 * n + 4;
			2: a = VOICE_BASE + 16 * n + 6;
			3: a = VOICE_BASE + 16 * n + $urandom_range(15);
			4: begin
				a = VOICE_BASE + 16 * n + 6;
				d = $urandom_range(200);
			end
			5: begin
				a = VOICE_BASE + 16 * n + 4;
				d = $urandom_range(6);
			end
			default: a = VOICE_BASE + 16 * n + 8;
		endcase
		return row(KIND_WORD, a, d);
	endfunction

	stim_row_t directed [$];
	stim_row_t r;
	mix_pair_t got;

	// Checks results and drives the result ready line.
	always @(posedge clk) begin
		if (arst_n) begin
			if (results.valid && results.ready) begin
				if (pending_mix.size() == 0) begin
					$display("%0t: unexpected result left=%0d right=%0d", $time,
						$signed(results.left_out), $signed(results.right_out));
					fails++;
				end else begin
					got = pending_mix.pop_front();
					if (results.left_out !== got.left || results.right_out !== got.right) begin
						$display("%0t: mix mismatch expected %0d/%0d actual %0d/%0d", $time,
							$signed(got.left), $signed(got.right),
							$signed(results.left_out), $signed(results.right_out));
						fails++;
					end
				end
			end
			results.ready <= idle_free || ($urandom_range(99) >= 15);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int ticks;
		fails = 0; cycles = 0; idle_free = 0;
		arst_n = 1'b0;
		items.valid = 0; items.kind = 0; items.bus_address = 0; items.write_data = 0;
		items.mem_address = 0; items.mem_data = 0;
		results.ready = 0; cfg.valid = 0; cfg.data = 0;
		clear_shadow();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle ticks, bad addresses, clamps, full scale and wrap addresses.
		directed.push_back(fixed_tick(0, 0));
		directed.push_back(row(KIND_LOAD, 0, 0, 16'hFFFF, 8'h80));
		directed.push_back(row(KIND_LOAD, 0, 0, 16'h0000, 8'h7F));
		directed.push_back(row(KIND_LOAD, 0, 0, 16'h0001, 8'h80));
		directed.push_back(row(KIND_LOAD, 0, 0, 16'h0002, 8'hFF));
		directed.push_back(row(KIND_PTR, VOICE_BASE + 16 * 3, 16'hFFFF));
		directed.push_back(row(KIND_PTR, 24'h000000, 16'h1234));
		directed.push_back(row(KIND_PTR, VOICE_BASE + 4, 16'h1234));
		directed.push_back(row(KIND_WORD, VOICE_BASE, 16'h0040));
		directed.push_back(row(KIND_WORD, 24'hFFFFFF, 16'hFFFF));
		directed.push_back(row(KIND_WORD, VOICE_BASE + 8, 16'h007F));
		directed.push_back(row(KIND_WORD, VOICE_BASE + 16 + 8, 16'h0040));
		directed.push_back(row(KIND_WORD, VOICE_BASE + 16 * 3 + 8, 16'hFF41));
		directed.push_back(row(KIND_WORD, VOICE_BASE + 6, 16'h0000));
		directed.push_back(row(KIND_WORD, VOICE_BASE + 16 + 6, 16'h0001));
		directed.push_back(row(KIND_WORD, VOICE_BASE + 16 * 3 + 6, 16'd113));
		directed.push_back(row(KIND_WORD, VOICE_BASE + 4, 16'h0000));
		directed.push_back(row(KIND_WORD, VOICE_BASE + 16 + 4, 16'hFFFF));
		directed.push_back(row(KIND_WORD, DMA_CTRL_ADDR, 16'h800B));
		// Voice 0 reads 127*64; voice 3 reads -128*64 at the top of RAM; voice 1 plays
		// the same byte as voice 0 on the right.
		directed.push_back(row(KIND_TICK, 0, 0));
		directed.push_back(row(KIND_TICK, 0, 0));
		directed.push_back(row(KIND_WORD, DMA_CTRL_ADDR, 16'h800B));
		directed.push_back(row(KIND_TICK, 0, 0));
		directed.push_back(row(KIND_WORD, DMA_CTRL_ADDR, 16'h000F));
		directed.push_back(fixed_tick(0, 0));
		// Short lengths keep later playback inside the loaded RAM.
		for (int n = 0; n < 4; n++)
			directed.push_back(row(KIND_WORD, VOICE_BASE + 16 * n + 4, 16'd2));
		foreach (directed[i]) send_item(directed[i]);

		// Random phases, each under its own rate ratio; extremes included.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_rate(23'd0);
				1: write_rate(23'd7405567);
				2: write_rate(RATE_RESET);
				3: write_rate($urandom_range(7405567));
				default: write_rate(23'h7FFFFF);
			endcase
			idle_free = (ph == 2);
			// Fill a small window of RAM so playback never hits an unwritten byte.
			for (int a = 0; a < 16; a++) begin
				r = row(KIND_LOAD, 0, 0, 16'(a * 7 + ph), $urandom);
				if (a == 0) r.mem_address = 16'hFFFF;
				send_item(r);
			end
			for (int i = 0; i < 100; i++) begin
				int k;
				logic [23:0] loff;
				k = $urandom_range(99);
				if (k < 50) r = row(KIND_TICK, $urandom, $urandom, $urandom, $urandom);
				else if (k < 75) r = random_write();
				else if (k < 83) r = row(KIND_WORD, DMA_CTRL_ADDR,
					{$urandom_range(1) == 1, 11'($urandom), 4'($urandom)});
				else if (k < 91) r = row(KIND_LOAD, 0, 0, $urandom, $urandom);
				else if (k < 95) r = row(KIND_PTR, VOICE_BASE + 16 * $urandom_range(3),
					16'(ph + 7 * $urandom_range(15)));
				else r = row(KIND_PTR, $urandom, $urandom);
				loff = r.bus_address - VOICE_BASE;
				// Keep voices away from unwritten RAM: load what a new start may read.
				if ((r.kind == KIND_PTR && r.bus_address >= VOICE_BASE &&
						r.bus_address < VOICE_BASE + VOICE_SPAN && loff[3:0] == OFF_PTR) ||
						(r.kind == KIND_WORD && r.bus_address == DMA_CTRL_ADDR &&
						r.write_data[15])) begin
					stim_row_t probe;
					probe = r;
					probe.kind = KIND_LOAD;
					probe.mem_address = r.write_data;
					probe.mem_data = $urandom;
					if (r.kind == KIND_PTR) begin
						for (int j = 0; j < 8; j++) begin
							probe.mem_address = 16'(r.write_data + j);
							probe.mem_data = $urandom;
							if (!ram_known[probe.mem_address]) send_item(probe);
						end
					end else begin
						for (int n = 0; n < 4; n++) if (r.write_data[n]) begin
							for (int j = 0; j < 8; j++) begin
								probe.mem_address = 16'(v_start[n] + j);
								probe.mem_data = $urandom;
								if (!ram_known[probe.mem_address]) send_item(probe);
							end
						end
					end
				end
				// Lengths beyond the loaded window would read unknown RAM.
				if (r.kind == KIND_WORD && r.bus_address >= VOICE_BASE &&
						r.bus_address < VOICE_BASE + VOICE_SPAN &&
						loff[3:0] == OFF_LEN && v_active[loff[5:4]] == 0)
					r.write_data = 16'($urandom_range(3, 1));
				else if (r.kind == KIND_WORD && r.bus_address >= VOICE_BASE &&
						r.bus_address < VOICE_BASE + VOICE_SPAN &&
						loff[3:0] == OFF_LEN)
					r.kind = KIND_TICK;
				send_item(r);
			end
		end

		items.valid <= 1'b0;
		while (pending_mix.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
